// ----- rtl/nmeachk_pkg.sv -----
package nmeachk_pkg;

   localparam int LINE_BUFFER_BYTES_DEFAULT = 96;
   localparam int MIN_REPORT_LEN = 6;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   localparam logic [23:0] TYPE_GGA = {8'h41, 8'h47, 8'h47};
   localparam logic [23:0] TYPE_RMC = {8'h43, 8'h4D, 8'h52};

   localparam logic [1:0] STATUS_NO_DOLLAR = 2'd0;
   localparam logic [1:0] STATUS_NO_STAR   = 2'd1;
   localparam logic [1:0] STATUS_MISMATCH  = 2'd2;
   localparam logic [1:0] STATUS_VALID     = 2'd3;

   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_GGA   = 2'd1;
   localparam logic [1:0] KIND_RMC   = 2'd2;

   localparam logic [4:0] HEX_NONE = 5'd16;

   typedef struct packed {
      logic [1:0] check_status;
      logic [1:0] sentence_kind;
      logic [7:0] computed_sum;
      logic [7:0] received_sum;
      logic [6:0] line_length;
   } result_type;

   // 0..15 for a hex digit, HEX_NONE otherwise
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = HEX_NONE;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 5'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 5'(c - 8'h37);
      end
      return v;
   endfunction

endpackage

// ----- rtl/nmeachk_line.sv -----
module nmeachk_line #(
   parameter int LINE_BUFFER_BYTES = nmeachk_pkg::LINE_BUFFER_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             rx_byte,
   output logic                   produce,
   output nmeachk_pkg::result_type result
);
   import nmeachk_pkg::*;

   localparam int CW = $clog2(LINE_BUFFER_BYTES);
   localparam logic [CW-1:0] MAX_CHARS = CW'(LINE_BUFFER_BYTES - 1);

   logic [CW-1:0] char_count_ff, char_count_in;
   logic          dollar_ff, dollar_in;
   logic [7:0]    xor_accum_ff, xor_accum_in;
   logic          star_seen_ff, star_seen_in;
   logic          text_ended_ff, text_ended_in;
   logic [7:0]    hex_accum_ff, hex_accum_in;
   logic          hex_stopped_ff, hex_stopped_in;
   logic [23:0]   type_chars_ff, type_chars_in;

   logic          is_term;
   logic [4:0]    hv;

   assign is_term = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
   assign hv      = hex_value(rx_byte);
   assign produce = fire && is_term && (char_count_ff > CW'(MIN_REPORT_LEN));

   always_comb begin
      priority if (!dollar_ff) begin
         result.check_status = STATUS_NO_DOLLAR;
      end else if (!star_seen_ff) begin
         result.check_status = STATUS_NO_STAR;
      end else if (xor_accum_ff != hex_accum_ff) begin
         result.check_status = STATUS_MISMATCH;
      end else begin
         result.check_status = STATUS_VALID;
      end
      priority if (type_chars_ff == TYPE_GGA) begin
         result.sentence_kind = KIND_GGA;
      end else if (type_chars_ff == TYPE_RMC) begin
         result.sentence_kind = KIND_RMC;
      end else begin
         result.sentence_kind = KIND_OTHER;
      end
      result.computed_sum = xor_accum_ff;
      result.received_sum = hex_accum_ff;
      result.line_length  = 7'(char_count_ff);
   end

   always_comb begin
      char_count_in  = char_count_ff;
      dollar_in      = dollar_ff;
      xor_accum_in   = xor_accum_ff;
      star_seen_in   = star_seen_ff;
      text_ended_in  = text_ended_ff;
      hex_accum_in   = hex_accum_ff;
      hex_stopped_in = hex_stopped_ff;
      type_chars_in  = type_chars_ff;
      if (fire) begin
         if (is_term) begin
            char_count_in  = '0;
            dollar_in      = 1'b0;
            xor_accum_in   = '0;
            star_seen_in   = 1'b0;
            text_ended_in  = 1'b0;
            hex_accum_in   = '0;
            hex_stopped_in = 1'b0;
            type_chars_in  = '0;
         end else if (char_count_ff < MAX_CHARS) begin
            if (char_count_ff == '0) begin
               dollar_in = (rx_byte == CHAR_DOLLAR);
            end else if (!star_seen_ff && !text_ended_ff) begin
               if (rx_byte == CHAR_NUL) begin
                  text_ended_in = 1'b1;
               end else if (rx_byte == CHAR_STAR) begin
                  star_seen_in = 1'b1;
               end else begin
                  xor_accum_in = xor_accum_ff ^ rx_byte;
               end
            end else if (star_seen_ff && !hex_stopped_ff) begin
               if (hv == HEX_NONE) begin
                  hex_stopped_in = 1'b1;
               end else begin
                  hex_accum_in = {hex_accum_ff[3:0], hv[3:0]};
               end
            end
            // capture the talker-stripped sentence type
            if (char_count_ff == CW'(3)) type_chars_in[7:0]   = rx_byte;
            if (char_count_ff == CW'(4)) type_chars_in[15:8]  = rx_byte;
            if (char_count_ff == CW'(5)) type_chars_in[23:16] = rx_byte;
            char_count_in = char_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff  <= '0;
         dollar_ff      <= 1'b0;
         xor_accum_ff   <= '0;
         star_seen_ff   <= 1'b0;
         text_ended_ff  <= 1'b0;
         hex_accum_ff   <= '0;
         hex_stopped_ff <= 1'b0;
         type_chars_ff  <= '0;
      end else begin
         char_count_ff  <= char_count_in;
         dollar_ff      <= dollar_in;
         xor_accum_ff   <= xor_accum_in;
         star_seen_ff   <= star_seen_in;
         text_ended_ff  <= text_ended_in;
         hex_accum_ff   <= hex_accum_in;
         hex_stopped_ff <= hex_stopped_in;
         type_chars_ff  <= type_chars_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      char_count_ff <= MAX_CHARS)
      else $error("line count past buffer size");

   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      fire && is_term |=> char_count_ff == '0 && !star_seen_ff && hex_accum_ff == '0)
      else $error("terminator did not clear line state");

   a_star_nul_excl: assert property (@(posedge clock) disable iff (reset)
      !(star_seen_ff && text_ended_ff))
      else $error("star and NUL both recorded");

   a_produce_len: assert property (@(posedge clock) disable iff (reset)
      produce |-> char_count_ff > CW'(MIN_REPORT_LEN))
      else $error("result from short line");
`endif

endmodule

// ----- rtl/nmea_sentence_framer_checker.sv -----
// NMEA sentence framer and checksum checker. Takes one serial byte per item on
// req_ and frames lines ended by CR or LF, keeping up to LINE_BUFFER_BYTES-1
// characters of a line. A terminator that closes a line of more than six
// stored characters yields one rsp_ item with the checksum status, sentence
// type (GGA/RMC/other), computed and received sums, and line length. One item
// per cycle sustained while rsp_ does not stall: a byte is held in the input
// register, then the per-line state and the result register update together;
// rsp_ stalls backpressure req_ only while the result register is occupied.
module nmea_sentence_framer_checker #(
   parameter int LINE_BUFFER_BYTES = nmeachk_pkg::LINE_BUFFER_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_check_status,
   output logic [1:0] rsp_sentence_kind,
   output logic [7:0] rsp_computed_sum,
   output logic [7:0] rsp_received_sum,
   output logic [6:0] rsp_line_length
);
   import nmeachk_pkg::*;

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       out_vld_ff, out_vld_in;
   result_type out_ff;
   logic       fire;
   logic       produce;
   result_type result;

   // advance the held byte only when the result register can take a new item
   assign fire      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || fire;
   assign in_vld_in = (req_valid && req_ready) || (in_vld_ff && !fire);
   assign out_vld_in = produce || (out_vld_ff && !rsp_ready);

   nmeachk_line #(
      .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
   ) u_line (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .rx_byte (in_byte_ff),
      .produce (produce),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_rx_byte;
      if (produce) out_ff <= result;
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_check_status  = out_ff.check_status;
   assign rsp_sentence_kind = out_ff.sentence_kind;
   assign rsp_computed_sum  = out_ff.computed_sum;
   assign rsp_received_sum  = out_ff.received_sum;
   assign rsp_line_length   = out_ff.line_length;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      produce |-> !out_vld_ff || rsp_ready)
      else $error("result overwrote an unaccepted item");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |-> req_ready)
      else $error("input register empty but not ready");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !fire |=> in_vld_ff && $stable(in_byte_ff))
      else $error("held byte lost while stalled");
`endif

endmodule
